// ===== hw/rtl/ico_pkg.sv =====
package ico_pkg;

    localparam int MAX_VERTICES  = 16384;
    localparam int TABLE_ENTRIES = 32768;
    localparam int VIDX_W        = $clog2(MAX_VERTICES);
    localparam int VCNT_W        = VIDX_W + 1;
    localparam int TADDR_W       = $clog2(TABLE_ENTRIES);
    localparam int TUSED_W       = TADDR_W + 1;
    localparam int KEY_W         = 2 * VIDX_W;
    localparam int ENTRY_W       = 1 + KEY_W + VIDX_W;
    localparam int VTX_W         = 48;
    localparam int BASE_COUNT    = 12;
    localparam int TRI_COUNT     = 20;

    localparam logic [14:0] HASH_MUL = 15'h79B1;

    localparam logic signed [15:0] CA = 16'sd8614;
    localparam logic signed [15:0] CB = 16'sd13937;
    localparam logic signed [15:0] CZ = 16'sd0;

    localparam logic FUNC_RESTART = 1'b0;
    localparam logic FUNC_SPLIT   = 1'b1;
    localparam logic KIND_VTX     = 1'b0;
    localparam logic KIND_TRI     = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_VFULL = 2'd1;
    localparam logic [1:0] ST_TFULL = 2'd2;

    function automatic logic [VTX_W-1:0] base_vtx(input logic [3:0] idx);
        logic [VTX_W-1:0] v;
        v = '0;
        case (idx)
            4'd0:    v = {-CA, CB, CZ};
            4'd1:    v = {CA, CB, CZ};
            4'd2:    v = {-CA, -CB, CZ};
            4'd3:    v = {CA, -CB, CZ};
            4'd4:    v = {CZ, -CA, CB};
            4'd5:    v = {CZ, CA, CB};
            4'd6:    v = {CZ, -CA, -CB};
            4'd7:    v = {CZ, CA, -CB};
            4'd8:    v = {CB, CZ, -CA};
            4'd9:    v = {CB, CZ, CA};
            4'd10:   v = {-CB, CZ, -CA};
            4'd11:   v = {-CB, CZ, CA};
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [11:0] base_tri(input logic [4:0] idx);
        logic [11:0] t;
        t = '0;
        case (idx)
            5'd0:    t = {4'd0, 4'd11, 4'd5};
            5'd1:    t = {4'd0, 4'd5, 4'd1};
            5'd2:    t = {4'd0, 4'd1, 4'd7};
            5'd3:    t = {4'd0, 4'd7, 4'd10};
            5'd4:    t = {4'd0, 4'd10, 4'd11};
            5'd5:    t = {4'd1, 4'd5, 4'd9};
            5'd6:    t = {4'd5, 4'd11, 4'd4};
            5'd7:    t = {4'd11, 4'd10, 4'd2};
            5'd8:    t = {4'd10, 4'd7, 4'd6};
            5'd9:    t = {4'd7, 4'd1, 4'd8};
            5'd10:   t = {4'd3, 4'd9, 4'd4};
            5'd11:   t = {4'd3, 4'd4, 4'd2};
            5'd12:   t = {4'd3, 4'd2, 4'd6};
            5'd13:   t = {4'd3, 4'd6, 4'd8};
            5'd14:   t = {4'd3, 4'd8, 4'd9};
            5'd15:   t = {4'd4, 4'd9, 4'd5};
            5'd16:   t = {4'd2, 4'd4, 4'd11};
            5'd17:   t = {4'd6, 4'd2, 4'd10};
            5'd18:   t = {4'd8, 4'd6, 4'd7};
            5'd19:   t = {4'd9, 4'd8, 4'd1};
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

// ===== hw/rtl/ico_ram.sv =====
module ico_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== hw/rtl/ico_norm.sv =====
module ico_norm import ico_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [16:0] i_sx,
    input  logic signed [16:0] i_sy,
    input  logic signed [16:0] i_sz,
    output logic               o_done,
    output logic signed [15:0] o_x,
    output logic signed [15:0] o_y,
    output logic signed [15:0] o_z
);

    typedef enum logic [2:0] {N_IDLE, N_SQ, N_DINIT, N_DIV, N_SQRT, N_FIN} t_nstate;

    t_nstate            r_state;
    logic [15:0]        r_mag [3];
    logic [2:0]         r_neg;
    logic [30:0]        r_sq [3];
    logic [31:0]        r_s;
    logic [1:0]         r_k;
    logic [4:0]         r_cnt;
    logic [31:0]        r_rem;
    logic [30:0]        r_q;
    logic [31:0]        r_res;
    logic [31:0]        r_bit;
    logic [30:0]        r_v;
    logic signed [15:0] r_out [3];

    logic [31:0] c_prod;
    logic [32:0] c_trial;
    logic [31:0] c_rb;
    logic [30:0] c_v;
    logic [15:0] c_m;
    logic [16:0] c_abs [3];

    always_comb begin
        c_abs[0] = i_sx[16] ? 17'(-i_sx) : 17'(i_sx);
        c_abs[1] = i_sy[16] ? 17'(-i_sy) : 17'(i_sy);
        c_abs[2] = i_sz[16] ? 17'(-i_sz) : 17'(i_sz);
        c_prod   = r_mag[r_k] * r_mag[r_k];
        c_trial  = {r_rem, (r_cnt == 5'd30) ? r_sq[r_k][0] : 1'b0};
        c_rb     = r_res + r_bit;
        c_v      = (r_cnt == 5'd15) ? r_q : r_v;
        c_m      = 16'((r_res + 32'd1) >> 1);
        if (c_m > 16'd16384) begin
            c_m = 16'd16384;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
            o_done  <= 1'b0;
        end else begin
            unique case (r_state)
                N_IDLE: begin
                    o_done <= 1'b0;
                    if (i_start) begin
                        for (int j = 0; j < 3; j++) begin
                            r_mag[j] <= c_abs[j][15:0];
                        end
                        r_neg   <= {i_sz[16], i_sy[16], i_sx[16]};
                        r_s     <= '0;
                        r_k     <= '0;
                        r_state <= N_SQ;
                    end
                end
                N_SQ: begin
                    r_sq[r_k] <= c_prod[30:0];
                    r_s       <= r_s + c_prod;
                    if (r_k == 2'd2) begin
                        r_k     <= '0;
                        r_state <= N_DINIT;
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                N_DINIT: begin
                    if (r_s == '0) begin
                        for (int j = 0; j < 3; j++) begin
                            r_out[j] <= '0;
                        end
                        o_done  <= 1'b1;
                        r_state <= N_IDLE;
                    end else begin
                        r_rem   <= {2'b0, r_sq[r_k][30:1]};
                        r_q     <= '0;
                        r_cnt   <= 5'd30;
                        r_state <= N_DIV;
                    end
                end
                N_DIV: begin
                    if (c_trial >= {1'b0, r_s}) begin
                        r_rem <= 32'(c_trial - {1'b0, r_s});
                        r_q   <= {r_q[29:0], 1'b1};
                    end else begin
                        r_rem <= c_trial[31:0];
                        r_q   <= {r_q[29:0], 1'b0};
                    end
                    if (r_cnt == '0) begin
                        r_cnt   <= 5'd15;
                        r_res   <= '0;
                        r_bit   <= 32'd1 << 30;
                        r_state <= N_SQRT;
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                N_SQRT: begin
                    if ({1'b0, c_v} >= c_rb) begin
                        r_v   <= 31'(c_v - c_rb[30:0]);
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_v   <= c_v;
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_cnt == '0) begin
                        r_state <= N_FIN;
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                N_FIN: begin
                    r_out[r_k] <= r_neg[r_k] ? -$signed(c_m) : $signed(c_m);
                    if (r_k == 2'd2) begin
                        o_done  <= 1'b1;
                        r_state <= N_IDLE;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= N_DINIT;
                    end
                end
                default: r_state <= N_IDLE;
            endcase
        end
    end

    assign o_x = r_out[0];
    assign o_y = r_out[1];
    assign o_z = r_out[2];

endmodule

// ===== hw/rtl/icosphere_triangle_subdivider.sv =====
// Restart item: table clear over all 32768 entries, then 32 records, one per cycle while the output is not stalled.
// Triangle item: per edge each table probe passes S_PRD and S_PCHK; a new midpoint
// goes through the shared normalizer (31-step divide, 16-step root per axis).
// One item at a time; results leave through a one-deep output register.
// Reset runs the same table clear and base load; no item is taken until done.
module icosphere_triangle_subdivider import ico_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_func,
    input  logic [13:0]        i_corner_a,
    input  logic [13:0]        i_corner_b,
    input  logic [13:0]        i_corner_c,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_kind,
    output logic [13:0]        o_index_a,
    output logic [13:0]        o_index_b,
    output logic [13:0]        o_index_c,
    output logic signed [15:0] o_coord_x,
    output logic signed [15:0] o_coord_y,
    output logic signed [15:0] o_coord_z,
    output logic [1:0]         o_status,
    output logic               o_last
);

    typedef enum logic [3:0] {
        S_CLR, S_BASE, S_IDLE, S_MP, S_PRD, S_PCHK, S_NEW,
        S_VA, S_VB, S_VC, S_NS, S_NW, S_WR, S_TRI, S_ERR
    } t_state;

    t_state                    r_state;
    logic                      r_emit;
    logic [TADDR_W-1:0]        r_cnt;
    logic [VIDX_W-1:0]         r_v [3];
    logic [VIDX_W-1:0]         r_m [3];
    logic [1:0]                r_edge;
    logic [VIDX_W-1:0]         r_p, r_q;
    logic [KEY_W-1:0]          r_key;
    logic [TADDR_W-1:0]        r_probe;
    logic [TUSED_W-1:0]        r_n;
    logic                      r_slot_ok;
    logic [VCNT_W-1:0]         r_vcnt;
    logic [TUSED_W-1:0]        r_used;
    logic signed [15:0]        r_px, r_py, r_pz;
    logic signed [16:0]        r_sx, r_sy, r_sz;
    logic [1:0]                r_st;

    logic                      out_free;
    logic                      c_emit;
    logic [VIDX_W-1:0]         c_p, c_q, c_lo, c_hi;
    logic [28:0]               c_hash;
    logic                      v_we;
    logic [VIDX_W-1:0]         v_waddr, v_raddr;
    logic [VTX_W-1:0]          v_wdata, v_rdata, v_mask;
    logic                      tab_we;
    logic [TADDR_W-1:0]        tab_waddr;
    logic [ENTRY_W-1:0]        tab_wdata, tab_rdata;
    logic                      nrm_start, nrm_done;
    logic signed [15:0]        nrm_x, nrm_y, nrm_z;
    logic [VTX_W-1:0]          c_bv;
    logic [11:0]               c_bt;
    logic [4:0]                c_ti;

    assign out_free = !o_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign c_emit   = out_free && (r_state inside {S_BASE, S_WR, S_TRI, S_ERR});

    always_comb begin
        c_p    = r_v[r_edge];
        c_q    = r_v[(r_edge == 2'd2) ? 2'd0 : r_edge + 2'd1];
        c_lo   = (c_p < c_q) ? c_p : c_q;
        c_hi   = (c_p < c_q) ? c_q : c_p;
        c_hash = c_hi * HASH_MUL;
        c_bv   = base_vtx(r_cnt[3:0]);
        c_ti   = r_cnt[4:0] - 5'(BASE_COUNT);
        c_bt   = base_tri(c_ti);
        v_raddr = (r_state == S_VA) ? r_p : r_q;
        v_mask  = ({1'b0, (r_state == S_VB) ? r_p : r_q} >= r_vcnt) ? '0 : v_rdata;
        nrm_start = (r_state == S_NS);
        if (r_state == S_CLR) begin
            v_we      = (r_cnt < TADDR_W'(BASE_COUNT));
            v_waddr   = VIDX_W'(r_cnt);
            v_wdata   = c_bv;
            tab_we    = 1'b1;
            tab_waddr = r_cnt;
            tab_wdata = '0;
        end else begin
            v_we      = (r_state == S_WR) && out_free;
            v_waddr   = r_vcnt[VIDX_W-1:0];
            v_wdata   = {nrm_x, nrm_y, nrm_z};
            tab_we    = (r_state == S_WR) && out_free;
            tab_waddr = r_probe;
            tab_wdata = {1'b1, r_key, r_vcnt[VIDX_W-1:0]};
        end
    end

    ico_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_vtx (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (v_waddr),
        .i_wdata (v_wdata),
        .i_raddr (v_raddr),
        .o_rdata (v_rdata)
    );

    ico_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_tab (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (tab_waddr),
        .i_wdata (tab_wdata),
        .i_raddr (r_probe),
        .o_rdata (tab_rdata)
    );

    ico_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (nrm_start),
        .i_sx    (r_sx),
        .i_sy    (r_sy),
        .i_sz    (r_sz),
        .o_done  (nrm_done),
        .o_x     (nrm_x),
        .o_y     (nrm_y),
        .o_z     (nrm_z)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_emit  <= 1'b0;
            r_cnt   <= '0;
            r_vcnt  <= VCNT_W'(BASE_COUNT);
            r_used  <= '0;
            o_valid <= 1'b0;
        end else begin
            if (c_emit) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    if (r_cnt == TADDR_W'(TABLE_ENTRIES - 1)) begin
                        r_vcnt  <= VCNT_W'(BASE_COUNT);
                        r_used  <= '0;
                        r_cnt   <= '0;
                        r_state <= r_emit ? S_BASE : S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_BASE: begin
                    if (out_free) begin
                        o_status <= ST_OK;
                        o_last   <= (r_cnt == TADDR_W'(BASE_COUNT + TRI_COUNT - 1));
                        if (r_cnt < TADDR_W'(BASE_COUNT)) begin
                            o_kind    <= KIND_VTX;
                            o_index_a <= VIDX_W'(r_cnt);
                            o_index_b <= '0;
                            o_index_c <= '0;
                            o_coord_x <= c_bv[47:32];
                            o_coord_y <= c_bv[31:16];
                            o_coord_z <= c_bv[15:0];
                        end else begin
                            o_kind    <= KIND_TRI;
                            o_index_a <= VIDX_W'(c_bt[11:8]);
                            o_index_b <= VIDX_W'(c_bt[7:4]);
                            o_index_c <= VIDX_W'(c_bt[3:0]);
                            o_coord_x <= '0;
                            o_coord_y <= '0;
                            o_coord_z <= '0;
                        end
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == TADDR_W'(BASE_COUNT + TRI_COUNT - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_cnt <= '0;
                        if (i_func == FUNC_RESTART) begin
                            r_emit  <= 1'b1;
                            r_state <= S_CLR;
                        end else begin
                            r_v[0]  <= i_corner_a;
                            r_v[1]  <= i_corner_b;
                            r_v[2]  <= i_corner_c;
                            r_edge  <= '0;
                            r_state <= S_MP;
                        end
                    end
                end
                S_MP: begin
                    r_p     <= c_p;
                    r_q     <= c_q;
                    r_key   <= {c_lo, c_hi};
                    r_probe <= c_hash[TADDR_W-1:0];
                    r_n     <= '0;
                    r_state <= S_PRD;
                end
                S_PRD: r_state <= S_PCHK;
                S_PCHK: begin
                    if (!tab_rdata[ENTRY_W-1]) begin
                        r_slot_ok <= 1'b1;
                        r_state   <= S_NEW;
                    end else if (tab_rdata[ENTRY_W-2 -: KEY_W] == r_key) begin
                        r_m[r_edge] <= tab_rdata[VIDX_W-1:0];
                        if (r_edge == 2'd2) begin
                            r_cnt   <= '0;
                            r_state <= S_TRI;
                        end else begin
                            r_edge  <= r_edge + 2'd1;
                            r_state <= S_MP;
                        end
                    end else if (r_n == TUSED_W'(TABLE_ENTRIES - 1)) begin
                        r_slot_ok <= 1'b0;
                        r_state   <= S_NEW;
                    end else begin
                        r_n     <= r_n + 1'b1;
                        r_probe <= r_probe + 1'b1;
                        r_state <= S_PRD;
                    end
                end
                S_NEW: begin
                    if (r_vcnt >= VCNT_W'(MAX_VERTICES)) begin
                        r_st    <= ST_VFULL;
                        r_state <= S_ERR;
                    end else if (r_used >= TUSED_W'(TABLE_ENTRIES) || !r_slot_ok) begin
                        r_st    <= ST_TFULL;
                        r_state <= S_ERR;
                    end else begin
                        r_state <= S_VA;
                    end
                end
                S_VA: r_state <= S_VB;
                S_VB: begin
                    r_px    <= v_mask[47:32];
                    r_py    <= v_mask[31:16];
                    r_pz    <= v_mask[15:0];
                    r_state <= S_VC;
                end
                S_VC: begin
                    r_sx    <= 17'(r_px) + 17'($signed(v_mask[47:32]));
                    r_sy    <= 17'(r_py) + 17'($signed(v_mask[31:16]));
                    r_sz    <= 17'(r_pz) + 17'($signed(v_mask[15:0]));
                    r_state <= S_NS;
                end
                S_NS: r_state <= S_NW;
                S_NW: begin
                    if (nrm_done) begin
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    if (out_free) begin
                        o_kind      <= KIND_VTX;
                        o_index_a   <= r_vcnt[VIDX_W-1:0];
                        o_index_b   <= '0;
                        o_index_c   <= '0;
                        o_coord_x   <= nrm_x;
                        o_coord_y   <= nrm_y;
                        o_coord_z   <= nrm_z;
                        o_status    <= ST_OK;
                        o_last      <= 1'b0;
                        r_m[r_edge] <= r_vcnt[VIDX_W-1:0];
                        r_vcnt      <= r_vcnt + 1'b1;
                        r_used      <= r_used + 1'b1;
                        if (r_edge == 2'd2) begin
                            r_cnt   <= '0;
                            r_state <= S_TRI;
                        end else begin
                            r_edge  <= r_edge + 2'd1;
                            r_state <= S_MP;
                        end
                    end
                end
                S_TRI: begin
                    if (out_free) begin
                        o_kind    <= KIND_TRI;
                        o_coord_x <= '0;
                        o_coord_y <= '0;
                        o_coord_z <= '0;
                        o_status  <= ST_OK;
                        o_last    <= (r_cnt[1:0] == 2'd3);
                        case (r_cnt[1:0])
                            2'd0: begin
                                o_index_a <= r_v[0];
                                o_index_b <= r_m[0];
                                o_index_c <= r_m[2];
                            end
                            2'd1: begin
                                o_index_a <= r_v[1];
                                o_index_b <= r_m[1];
                                o_index_c <= r_m[0];
                            end
                            2'd2: begin
                                o_index_a <= r_v[2];
                                o_index_b <= r_m[2];
                                o_index_c <= r_m[1];
                            end
                            default: begin
                                o_index_a <= r_m[0];
                                o_index_b <= r_m[1];
                                o_index_c <= r_m[2];
                            end
                        endcase
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt[1:0] == 2'd3) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_ERR: begin
                    if (out_free) begin
                        o_kind    <= KIND_VTX;
                        o_index_a <= '0;
                        o_index_b <= '0;
                        o_index_c <= '0;
                        o_coord_x <= '0;
                        o_coord_y <= '0;
                        o_coord_z <= '0;
                        o_status  <= r_st;
                        o_last    <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_vcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vcnt <= VCNT_W'(MAX_VERTICES))
        else $error("vertex count beyond store depth");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_last && o_kind == KIND_VTX))
        else $error("error record not final");

    a_norm_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        nrm_done |-> (r_state == S_NW))
        else $error("normalizer finished outside wait");

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    import ico_pkg::*;

    typedef struct {
        logic                kind;
        logic [13:0]         ia;
        logic [13:0]         ib;
        logic [13:0]         ic;
        logic signed [15:0]  x;
        logic signed [15:0]  y;
        logic signed [15:0]  z;
        logic [1:0]          st;
        logic                last;
    } t_rec;

    typedef struct {
        logic [13:0] a;
        logic [13:0] b;
        logic [13:0] c;
    } t_tri;

    class subdiv_scoreboard;
        logic signed [15:0] vx[MAX_VERTICES];
        logic signed [15:0] vy[MAX_VERTICES];
        logic signed [15:0] vz[MAX_VERTICES];
        int unsigned        vcount;
        int unsigned        hiwater;
        int unsigned        used;
        bit                 tvalid[TABLE_ENTRIES];
        int unsigned        tkey[TABLE_ENTRIES];
        int unsigned        tval[TABLE_ENTRIES];
        t_rec               expected[$];
        t_tri               faces[$];
        int                 errors;

        function new();
            errors = 0;
            hiwater = BASE_COUNT;
            restart();
        endfunction

        function void restart();
            logic [VTX_W-1:0] v;
            for (int i = 0; i < TABLE_ENTRIES; i++) tvalid[i] = 0;
            for (int i = 0; i < BASE_COUNT; i++) begin
                v = base_vtx(4'(i));
                vx[i] = v[47:32];
                vy[i] = v[31:16];
                vz[i] = v[15:0];
            end
            vcount = BASE_COUNT;
            used = 0;
        endfunction

        function void emit(logic kind, int unsigned a, int unsigned b, int unsigned c,
                           logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] z, logic [1:0] st);
            t_rec r;
            t_tri t;
            r.kind = kind;
            r.ia = a[13:0];
            r.ib = b[13:0];
            r.ic = c[13:0];
            r.x = x;
            r.y = y;
            r.z = z;
            r.st = st;
            r.last = 0;
            expected.insert(expected.size(), r);
            if (kind == KIND_TRI) begin
                t.a = r.ia;
                t.b = r.ib;
                t.c = r.ic;
                faces.insert(faces.size(), t);
                if (faces.size() > 4000) void'(faces.pop_front());
            end
        endfunction

        function longint unsigned root(longint unsigned v);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function logic signed [15:0] unit_axis(int c, longint unsigned s);
            longint unsigned mag, m;
            mag = (c < 0) ? -c : c;
            m = (root(((mag * mag) << 30) / s) + 1) >> 1;
            if (m > 16384) m = 16384;
            return (c < 0) ? -$signed(m[15:0]) : $signed(m[15:0]);
        endfunction

        function int axis(int unsigned idx, int j);
            if (idx >= vcount) return 0;
            return (j == 0) ? vx[idx] : (j == 1) ? vy[idx] : vz[idx];
        endfunction

        function int edge_mid(int unsigned p, int unsigned q, output int unsigned m);
            int unsigned lo, hi, key, h, e, slot;
            longint unsigned prod, s;
            int sx, sy, sz;
            logic signed [15:0] nx, ny, nz;
            lo = (p < q) ? p : q;
            hi = (p < q) ? q : p;
            key = (lo << 16) | hi;
            prod = longint'(key) * 64'd2654435761;
            h = prod % TABLE_ENTRIES;
            slot = TABLE_ENTRIES;
            m = 0;
            for (int n = 0; n < TABLE_ENTRIES; n++) begin
                e = (h + n) % TABLE_ENTRIES;
                if (!tvalid[e]) begin
                    slot = e;
                    break;
                end
                if (tkey[e] == key) begin
                    m = tval[e];
                    return ST_OK;
                end
            end
            if (vcount >= MAX_VERTICES) return ST_VFULL;
            if (used >= TABLE_ENTRIES || slot >= TABLE_ENTRIES) return ST_TFULL;
            sx = axis(p, 0) + axis(q, 0);
            sy = axis(p, 1) + axis(q, 1);
            sz = axis(p, 2) + axis(q, 2);
            s = longint'(sx) * sx + longint'(sy) * sy + longint'(sz) * sz;
            nx = 0;
            ny = 0;
            nz = 0;
            if (s != 0) begin
                nx = unit_axis(sx, s);
                ny = unit_axis(sy, s);
                nz = unit_axis(sz, s);
            end
            vx[vcount] = nx;
            vy[vcount] = ny;
            vz[vcount] = nz;
            m = vcount;
            vcount++;
            if (vcount > hiwater) hiwater = vcount;
            tvalid[slot] = 1;
            tkey[slot] = key;
            tval[slot] = m;
            used++;
            emit(KIND_VTX, m, 0, 0, nx, ny, nz, ST_OK);
            return ST_OK;
        endfunction

        function void note_transfer(logic f, logic [13:0] a, logic [13:0] b, logic [13:0] c);
            int unsigned v[3];
            int unsigned m[3];
            int st;
            logic [11:0] t;
            if (f == FUNC_RESTART) begin
                restart();
                for (int i = 0; i < BASE_COUNT; i++)
                    emit(KIND_VTX, i, 0, 0, vx[i], vy[i], vz[i], ST_OK);
                for (int i = 0; i < TRI_COUNT; i++) begin
                    t = base_tri(5'(i));
                    emit(KIND_TRI, t[11:8], t[7:4], t[3:0], 0, 0, 0, ST_OK);
                end
                expected[$].last = 1;
                return;
            end
            v[0] = a;
            v[1] = b;
            v[2] = c;
            for (int i = 0; i < 3; i++) begin
                st = edge_mid(v[i], v[(i + 1) % 3], m[i]);
                if (st != ST_OK) begin
                    emit(KIND_VTX, 0, 0, 0, 0, 0, 0, 2'(st));
                    expected[$].last = 1;
                    return;
                end
            end
            emit(KIND_TRI, v[0], m[0], m[2], 0, 0, 0, ST_OK);
            emit(KIND_TRI, v[1], m[1], m[0], 0, 0, 0, ST_OK);
            emit(KIND_TRI, v[2], m[2], m[1], 0, 0, 0, ST_OK);
            emit(KIND_TRI, m[0], m[1], m[2], 0, 0, 0, ST_OK);
            expected[$].last = 1;
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check_result(t_rec got);
            t_rec w;
            if (expected.size() == 0) begin
                report("unexpected result index_a", got.ia, -1);
                return;
            end
            w = expected.pop_front();
            if (got.kind !== w.kind) report("kind", got.kind, w.kind);
            if (got.ia !== w.ia) report("index_a", got.ia, w.ia);
            if (got.ib !== w.ib) report("index_b", got.ib, w.ib);
            if (got.ic !== w.ic) report("index_c", got.ic, w.ic);
            if (got.x !== w.x) report("coord_x", got.x, w.x);
            if (got.y !== w.y) report("coord_y", got.y, w.y);
            if (got.z !== w.z) report("coord_z", got.z, w.z);
            if (got.st !== w.st) report("status", got.st, w.st);
            if (got.last !== w.last) report("last", got.last, w.last);
        endtask
    endclass

    localparam int LIMIT = 40000000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic               i_func;
    logic [13:0]        i_corner_a;
    logic [13:0]        i_corner_b;
    logic [13:0]        i_corner_c;
    logic               o_valid;
    logic               i_stall;
    logic               o_kind;
    logic [13:0]        o_index_a;
    logic [13:0]        o_index_b;
    logic [13:0]        o_index_c;
    logic signed [15:0] o_coord_x;
    logic signed [15:0] o_coord_y;
    logic signed [15:0] o_coord_z;
    logic [1:0]         o_status;
    logic               o_last;

    subdiv_scoreboard sb;
    bit               quiet;
    logic             hold_go;
    bit               hold_done;
    int               hold_left;
    int               cycles;

    icosphere_triangle_subdivider uut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1;
        end else if (hold_go && !hold_done) begin
            hold_done = 1;
            hold_left = 3000;
            i_stall <= 1;
        end else begin
            i_stall <= !quiet && ($urandom_range(99) < 11);
        end
    end

    always @(posedge i_clk) begin
        t_rec r;
        if (i_rst_n && o_valid && !i_stall) begin
            r.kind = o_kind;
            r.ia = o_index_a;
            r.ib = o_index_b;
            r.ic = o_index_c;
            r.x = o_coord_x;
            r.y = o_coord_y;
            r.z = o_coord_z;
            r.st = o_status;
            r.last = o_last;
            sb.check_result(r);
        end
    end

    task automatic send_item(logic f, logic [13:0] a, logic [13:0] b, logic [13:0] c);
        while (!quiet && $urandom_range(99) < 11) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_func <= f;
        i_corner_a <= a;
        i_corner_b <= b;
        i_corner_c <= c;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_transfer(f, a, b, c);
    endtask

    task automatic split(logic [13:0] a, logic [13:0] b, logic [13:0] c);
        send_item(FUNC_SPLIT, a, b, c);
    endtask

    function automatic logic [13:0] any_vertex();
        return 14'($urandom_range(sb.hiwater - 1));
    endfunction

    task automatic split_face();
        t_tri t;
        t = sb.faces[$urandom_range(sb.faces.size() - 1)];
        split(t.a, t.b, t.c);
    endtask

    initial begin
        int r;
        logic [13:0] a;
        sb = new();
        cycles = 0;
        quiet = 0;
        hold_go <= 0;
        hold_done = 0;
        hold_left = 0;
        i_rst_n <= 0;
        i_valid <= 0;
        i_stall <= 0;
        i_func <= FUNC_RESTART;
        i_corner_a <= 0;
        i_corner_b <= 0;
        i_corner_c <= 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;

        split(0, 11, 5);
        split(0, 11, 5);
        split(5, 11, 0);
        split(0, 3, 1);
        split(3, 0, 1);
        split(4, 4, 4);
        split(1, 1, 2);
        split(12, 13, 14);
        split(14'(sb.vcount - 1), 0, 14'(sb.vcount - 2));
        send_item(FUNC_RESTART, 0, 0, 0);
        split(0, 12, 13);
        split(14, 15, 16);
        split(7, 7, 8);
        split(9, 10, 6);
        send_item(FUNC_RESTART, 14'h3FFF, 14'h2AAA, 14'h1555);
        split(2, 3, 6);

        for (int n = 0; n < 285; n++) begin
            quiet = (n >= 120 && n < 170);
            r = $urandom_range(99);
            if (n == 60) begin
                hold_go <= 1;
                send_item(FUNC_RESTART, any_vertex(), any_vertex(), any_vertex());
            end else if (r < 2) begin
                send_item(FUNC_RESTART, any_vertex(), any_vertex(), any_vertex());
            end else if (r < 82 && sb.faces.size() > 0) begin
                split_face();
            end else if (r < 88) begin
                a = any_vertex();
                split(a, a, any_vertex());
            end else begin
                split(any_vertex(), any_vertex(), any_vertex());
            end
        end
        i_valid <= 0;
        quiet = 0;

        while (sb.expected.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

// ===== icosphere_triangle_subdivider.f =====
hw/rtl/ico_pkg.sv
hw/rtl/ico_ram.sv
hw/rtl/ico_norm.sv
hw/rtl/icosphere_triangle_subdivider.sv
tb/sv/testbench.sv
